/* hw/rtl/mmi_pkg.sv */
package mmi_pkg;

  // Number of buttons that produce change events after a physical report
  localparam int EventButtons = 5;

  typedef enum logic [2:0] {
    CMD_MOVE   = 3'd0,
    CMD_BUTTON = 3'd1,
    CMD_REPORT = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ACT_DOWN  = 2'd0,
    ACT_UP    = 2'd1,
    ACT_CLICK = 2'd2,
    ACT_NONE  = 2'd3
  } btn_action_t;

  typedef enum logic [1:0] {
    RES_REPORT = 2'd0,
    RES_EVENT  = 2'd1,
    RES_SYNTH  = 2'd2,
    RES_STATE  = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_X_POS   = 2'd1,
    CFG_Y_POS   = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_index_t;

  // One result group: a head result plus the button events that follow it
  typedef struct packed {
    res_kind_t               kind;
    logic signed [15:0]      x;
    logic signed [15:0]      y;
    logic signed [7:0]       wheel;
    logic [7:0]              mask;
    logic                    merged;
    logic [EventButtons-1:0] evt;
  } mmi_group_t;

  // Push of one result group from the command core to the emitter
  typedef struct packed {
    logic       push;
    mmi_group_t group;
  } mmi_push_t;

endpackage

/* hw/rtl/mmi_core.sv */
module mmi_core
  import mmi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [2:0]         kind,
  input  logic signed [31:0] move_dx,
  input  logic signed [31:0] move_dy,
  input  logic signed [31:0] move_wheel,
  input  logic [7:0]         button_id,
  input  logic [1:0]         button_action,
  input  logic [7:0]         report_buttons,
  input  logic signed [15:0] report_x,
  input  logic signed [15:0] report_y,
  input  logic [6:0]         report_length,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  output mmi_push_t          push_out
);

  logic              enabled;
  logic [5:0]        x_position;
  logic [5:0]        y_position;
  logic [31:0]       pending_x;
  logic [31:0]       pending_y;
  logic [31:0]       pending_scroll;
  logic [7:0]        held_buttons;

  logic [31:0]       pending_x_next;
  logic [31:0]       pending_y_next;
  logic [31:0]       pending_scroll_next;
  logic [7:0]        held_buttons_next;
  mmi_push_t         push_next;

  logic              merge_ok;
  logic              any_xy;
  logic              any_pending;
  logic [7:0]        btn_bit;
  logic [7:0]        new_mask;
  logic [7:0]        changed;
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > 33'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [31:0] v);
    logic signed [7:0] r;
    if (v > 32'sd127) begin
      r = 8'sh7F;
    end else if (v < -32'sd128) begin
      r = 8'sh80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Decode merge validity and button mask updates
  always_comb begin
    merge_ok = enabled && (x_position != 6'd0) && (y_position != 6'd0) &&
               ({1'b0, x_position} + 7'd2 <= report_length) &&
               ({1'b0, y_position} + 7'd2 <= report_length);
    any_xy      = (pending_x != 32'd0) || (pending_y != 32'd0);
    any_pending = any_xy || (pending_scroll != 32'd0);
    btn_bit     = 8'd1 << (button_id[2:0] - 3'd1);
    new_mask    = (report_length >= 7'd2) ? report_buttons : 8'd0;
    changed     = held_buttons ^ new_mask;
    sum_x = 33'(report_x) + 33'(signed'(pending_x));
    sum_y = 33'(report_y) + 33'(signed'(pending_y));
  end

  // Compute next state and the result group for the current command
  always_comb begin
    pending_x_next      = pending_x;
    pending_y_next      = pending_y;
    pending_scroll_next = pending_scroll;
    held_buttons_next   = held_buttons;
    push_next.push         = 1'b0;
    push_next.group.kind   = RES_REPORT;
    push_next.group.x      = 16'sd0;
    push_next.group.y      = 16'sd0;
    push_next.group.wheel  = 8'sd0;
    push_next.group.mask   = held_buttons;
    push_next.group.merged = 1'b0;
    push_next.group.evt    = '0;
    unique case (kind)
      CMD_MOVE: begin
        pending_x_next      = pending_x + move_dx;
        pending_y_next      = pending_y + move_dy;
        pending_scroll_next = pending_scroll + move_wheel;
      end
      CMD_BUTTON: begin
        if (button_id >= 8'd1 && button_id <= 8'd8) begin
          unique case (button_action)
            ACT_DOWN, ACT_CLICK: held_buttons_next = held_buttons | btn_bit;
            ACT_UP:              held_buttons_next = held_buttons & ~btn_bit;
            default:             held_buttons_next = held_buttons;
          endcase
        end
      end
      CMD_REPORT: begin
        push_next.push    = 1'b1;
        push_next.group.x = report_x;
        push_next.group.y = report_y;
        if (merge_ok) begin
          pending_x_next = 32'd0;
          pending_y_next = 32'd0;
          if (any_xy) begin
            push_next.group.x      = sat16(sum_x);
            push_next.group.y      = sat16(sum_y);
            push_next.group.merged = 1'b1;
          end
        end
        if (enabled) begin
          held_buttons_next    = new_mask;
          push_next.group.mask = new_mask;
          push_next.group.evt  = changed[EventButtons-1:0];
        end
      end
      CMD_TICK: begin
        pending_x_next      = 32'd0;
        pending_y_next      = 32'd0;
        pending_scroll_next = 32'd0;
        push_next.push        = any_pending;
        push_next.group.kind  = RES_SYNTH;
        push_next.group.x     = 16'(sat8(signed'(pending_x)));
        push_next.group.y     = 16'(sat8(signed'(pending_y)));
        push_next.group.wheel = sat8(signed'(pending_scroll));
      end
      CMD_QUERY: begin
        push_next.push       = 1'b1;
        push_next.group.kind = RES_STATE;
      end
      default: begin
        push_next.push = 1'b0;
      end
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      x_position <= 6'd0;
      y_position <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED: enabled    <= cfg_data[0];
        CFG_X_POS:   x_position <= cfg_data;
        CFG_Y_POS:   y_position <= cfg_data;
        default:     enabled    <= enabled;
      endcase
    end
  end

  // Advance accumulator state and register the result group
  always_ff @(posedge clk) begin
    if (take) begin
      push_out.group <= push_next.group;
    end
    if (rst) begin
      pending_x      <= 32'd0;
      pending_y      <= 32'd0;
      pending_scroll <= 32'd0;
      held_buttons   <= 8'd0;
      push_out.push  <= 1'b0;
    end else begin
      push_out.push <= take && push_next.push;
      if (take) begin
        pending_x      <= pending_x_next;
        pending_y      <= pending_y_next;
        pending_scroll <= pending_scroll_next;
        held_buttons   <= held_buttons_next;
      end
    end
  end

endmodule

/* hw/rtl/mmi_emit.sv */
module mmi_emit
  import mmi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mmi_push_t          push_in,
  output logic [1:0]         room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [7:0]  out_wheel,
  output logic [7:0]         out_mask,
  output logic [2:0]         event_button,
  output logic               event_pressed,
  output logic               was_merged,
  output logic               last
);

  localparam int Depth = 2;

  mmi_group_t              queue [Depth];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  mmi_group_t              cur;
  logic                    cur_valid;
  logic                    head_pend;

  logic [EventButtons-1:0] first;
  logic [2:0]              first_num;
  logic                    beat_done;
  logic                    load;
  logic                    pop;

  // Pick the lowest pending event and shape the current beat
  always_comb begin
    first     = cur.evt & (~cur.evt + EventButtons'(1));
    first_num = 3'd0;
    for (int i = 0; i < EventButtons; i++) begin
      if (first[i]) begin
        first_num = 3'(i + 1);
      end
    end
    out_valid = cur_valid;
    out_mask  = cur.mask;
    if (head_pend) begin
      result_kind   = cur.kind;
      out_x         = cur.x;
      out_y         = cur.y;
      out_wheel     = cur.wheel;
      event_button  = 3'd0;
      event_pressed = 1'b0;
      was_merged    = cur.merged;
      last          = (cur.evt == '0);
    end else begin
      result_kind   = RES_EVENT;
      out_x         = 16'sd0;
      out_y         = 16'sd0;
      out_wheel     = 8'sd0;
      event_button  = first_num;
      event_pressed = |(first & cur.mask[EventButtons-1:0]);
      was_merged    = 1'b0;
      last          = ((cur.evt & ~first) == '0);
    end
    beat_done = cur_valid && out_ready;
    load      = (!cur_valid || (beat_done && last)) && (count != 2'd0);
    pop       = load;
    room      = 2'(Depth) - count;
  end

  // Track queue occupancy and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push_in.push) - 2'(pop);
    end
  end

  // Store result groups
  always_ff @(posedge clk) begin
    if (push_in.push) begin
      queue[wr_ptr] <= push_in.group;
    end
  end

  // Advance through the current group one beat at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      head_pend <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
      head_pend <= 1'b1;
    end else if (beat_done) begin
      if (last) begin
        cur_valid <= 1'b0;
      end
      head_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= queue[rd_ptr];
    end else if (beat_done && !head_pend) begin
      cur.evt <= cur.evt & ~first;
    end
  end

endmodule

/* hw/rtl/mouse_motion_injector.sv */
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+---------------------------------------
// in       | input     | in_valid / in_ready  | kind, move_*, button_*, report_*
// out      | output    | out_valid / out_ready| result_kind, out_*, event_*, last
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An input beat updates state as soon as it is taken. in_ready drops when the queue
// is full, or would keep only one free slot with a group still in flight, so a steady
// stream of result-making beats stalls even under a free output.
// Each result group leaves as 1 to 1+EventButtons beats, one per cycle while out_ready
// is high, after passing the core's push register, the queue and the current group.
// Reset clears state, registers and queue; output stalls back up; cfg_ready is high.
module mouse_motion_injector
  import mmi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic signed [31:0] move_dx,
  input  logic signed [31:0] move_dy,
  input  logic signed [31:0] move_wheel,
  input  logic [7:0]         button_id,
  input  logic [1:0]         button_action,
  input  logic [7:0]         report_buttons,
  input  logic signed [15:0] report_x,
  input  logic signed [15:0] report_y,
  input  logic [6:0]         report_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [7:0]  out_wheel,
  output logic [7:0]         out_mask,
  output logic [2:0]         event_button,
  output logic               event_pressed,
  output logic               was_merged,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  mmi_push_t  push;
  logic [1:0] room;
  logic       take;

  // Accept a command only when the queue can hold a group beyond one in flight
  assign in_ready  = (room > 2'd1) || ((room == 2'd1) && !push.push);
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  mmi_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .kind           (kind),
    .move_dx        (move_dx),
    .move_dy        (move_dy),
    .move_wheel     (move_wheel),
    .button_id      (button_id),
    .button_action  (button_action),
    .report_buttons (report_buttons),
    .report_x       (report_x),
    .report_y       (report_y),
    .report_length  (report_length),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push_out       (push)
  );

  mmi_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .push_in       (push),
    .room          (room),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_wheel     (out_wheel),
    .out_mask      (out_mask),
    .event_button  (event_button),
    .event_pressed (event_pressed),
    .was_merged    (was_merged),
    .last          (last)
  );

endmodule
